// ===== src/mpc_pkg.sv =====
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared widths, reset values and register indexes of the escape-time
// pixel coloring block.
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int FRAC_BITS = 28;
  localparam int Q_W       = FRAC_BITS + 4;
  localparam int PROD_W    = 2 * Q_W;
  localparam int ITER_W    = 16;
  localparam int SIZE_W    = 13;
  localparam int POS_W     = 12;
  localparam int STEP_W    = 31;
  localparam int COLOR_W   = 8;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd1000;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd1000;
  localparam logic [ITER_W-1:0] LIMIT_RST  = 16'd1000;
  localparam logic [STEP_W-1:0] STEP_RST   = 31'd1073742;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_LIMIT  = 2'd2,
    CFG_STEP   = 2'd3
  } cfg_idx_t;

endpackage

// ===== src/mandelbrot_pixel_color.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_pixel_color
// Escape-time color of one pixel, built on one shared 32x32 multiplier and
// one shared restoring divider stepped by a small sequencer.
// ----------------------------------------------------------------------------
// sequence: S_CR and S_CI scale the pixel offsets by the step, then each iteration
//   steps through S_RR (|zr|^2), S_II (|zi|^2), S_RI (|zr*zi|) and S_UPD (update)
//   until the point escapes or n reaches the limit (n = escape_count); each color
//   channel then takes S_COL and S_DIV, one quotient bit per S_DIV step; a zero limit gives black
// in_tready is high only while idle; a result waiting in the output register does not block it
// synchronous active-low reset: registers return to 1000/1000/1000/1073742
module mandelbrot_pixel_color
  import mpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_x[11:0], pixel_y[23:12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // red[7:0], green[15:8], blue[23:16], escape_count[39:24]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_CR, S_CI, S_INIT, S_RR, S_II, S_RI, S_UPD, S_COL, S_DIV, S_DONE
  } state_t;

  localparam logic [PROD_W:0] THR = (PROD_W+1)'(1) << (2 * FRAC_BITS + 2);
  localparam logic [Q_W-1:0]  Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0]  Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  state_t              state_r;
  logic [SIZE_W-1:0]   width_r, height_r;
  logic [ITER_W-1:0]   limit_r;
  logic [STEP_W-1:0]   step_r;
  logic [POS_W-1:0]    px_r, py_r;
  logic [Q_W-1:0]      cr_r, ci_r, zr_r, zi_r;
  logic [PROD_W-1:0]   prod_r, rr_r;
  logic signed [PROD_W:0] diff_r;
  logic                esc_r;
  logic [ITER_W-1:0]   n_r;
  logic [1:0]          ch_r;
  logic [2:0]          cnt_r;
  logic [23:0]         rem_r;
  logic [22:0]         dvs_r;
  logic [COLOR_W-1:0]  q_r;
  logic [COLOR_W-1:0]  col_r [3];
  logic                out_valid_r;
  logic [39:0]         out_data_r;

  logic [Q_W-1:0]      mul_a, mul_b, ar, ai;
  logic signed [15:0]  dx, dy;
  logic [15:0]         dx_abs, dy_abs;
  logic [PROD_W:0]     sq_sum;
  logic signed [PROD_W:0] ri_s;
  logic signed [PROD_W+1:0] wr, wi;
  logic [16:0]         t2, u1, u2;
  logic [17:0]         t3, s1, s2, s3;
  logic [ITER_W-1:0]   m;
  logic [23:0]         numer;
  logic                out_free;

  function automatic logic [Q_W-1:0] sat_q(input logic signed [PROD_W+1:0] v);
    if ((&v[PROD_W+1:Q_W-1]) || !(|v[PROD_W+1:Q_W-1])) begin
      return v[Q_W-1:0];
    end
    return v[PROD_W+1] ? Q_MIN : Q_MAX;
  endfunction

  // floor of half the signed step product, saturated
  function automatic logic [Q_W-1:0] to_coord(input logic [PROD_W-1:0] p,
                                              input logic neg);
    logic signed [46:0] s;
    logic signed [46:0] h;
    s = neg ? -$signed({2'b00, p[44:0]}) : $signed({2'b00, p[44:0]});
    h = s >>> 1;
    return sat_q((PROD_W+2)'(h));
  endfunction

  assign dx = $signed({3'b000, px_r, 1'b0}) - $signed({3'b000, width_r});
  assign dy = $signed({3'b000, py_r, 1'b0}) - $signed({3'b000, height_r});
  assign dx_abs = dx[15] ? 16'(-dx) : 16'(dx);
  assign dy_abs = dy[15] ? 16'(-dy) : 16'(dy);
  assign ar = zr_r[Q_W-1] ? (Q_W'(0) - zr_r) : zr_r;
  assign ai = zi_r[Q_W-1] ? (Q_W'(0) - zi_r) : zi_r;

  always_comb begin
    unique case (state_r)
      S_CR: begin
        mul_a = Q_W'(dx_abs);
        mul_b = Q_W'(step_r);
      end
      S_CI: begin
        mul_a = Q_W'(dy_abs);
        mul_b = Q_W'(step_r);
      end
      S_RR: begin
        mul_a = ar;
        mul_b = ar;
      end
      S_II: begin
        mul_a = ai;
        mul_b = ai;
      end
      default: begin
        mul_a = ar;
        mul_b = ai;
      end
    endcase
  end

  assign sq_sum = {1'b0, rr_r} + {1'b0, prod_r};
  assign ri_s   = (zr_r[Q_W-1] != zi_r[Q_W-1]) ? -$signed({1'b0, prod_r})
                                               : $signed({1'b0, prod_r});
  assign wr = (PROD_W+2)'(diff_r >>> FRAC_BITS) + (PROD_W+2)'($signed(cr_r));
  assign wi = (PROD_W+2)'(ri_s >>> (FRAC_BITS - 1)) + (PROD_W+2)'($signed(ci_r));

  // channel numerators: n, 2n mod limit, 3n mod limit (n may equal limit)
  assign t2 = {n_r, 1'b0};
  assign u1 = (t2 >= 17'(limit_r)) ? t2 - 17'(limit_r) : t2;
  assign u2 = (u1 >= 17'(limit_r)) ? u1 - 17'(limit_r) : u1;
  assign t3 = 18'(n_r) + 18'(t2);
  assign s1 = (t3 >= 18'(limit_r)) ? t3 - 18'(limit_r) : t3;
  assign s2 = (s1 >= 18'(limit_r)) ? s1 - 18'(limit_r) : s1;
  assign s3 = (s2 >= 18'(limit_r)) ? s2 - 18'(limit_r) : s2;

  always_comb begin
    unique case (ch_r)
      2'd0:    m = n_r;
      2'd1:    m = u2[15:0];
      default: m = s3[15:0];
    endcase
  end

  assign numer    = {m, 8'b0} - 24'(m);
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      limit_r     <= LIMIT_RST;
      step_r      <= STEP_RST;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_WIDTH:  width_r  <= cfg_data[SIZE_W-1:0];
          CFG_HEIGHT: height_r <= cfg_data[SIZE_W-1:0];
          CFG_LIMIT:  limit_r  <= cfg_data[ITER_W-1:0];
          CFG_STEP:   step_r   <= cfg_data;
        endcase
      end

      // in S_DONE a free output register is reloaded below
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            px_r    <= in_tdata[11:0];
            py_r    <= in_tdata[23:12];
            state_r <= S_CR;
          end
        end
        S_CR: state_r <= S_CI;
        S_CI: begin
          cr_r    <= to_coord(prod_r, dx[15]);
          state_r <= S_INIT;
        end
        S_INIT: begin
          ci_r    <= to_coord(prod_r, dy[15]);
          zr_r    <= '0;
          zi_r    <= '0;
          n_r     <= '0;
          state_r <= S_RR;
        end
        S_RR: begin
          state_r <= (n_r >= limit_r) ? S_COL : S_II;
        end
        S_II: begin
          rr_r    <= prod_r;
          state_r <= S_RI;
        end
        S_RI: begin
          esc_r   <= sq_sum > THR;
          diff_r  <= $signed({1'b0, rr_r}) - $signed({1'b0, prod_r});
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (esc_r) begin
            state_r <= S_COL;
          end else begin
            zr_r    <= sat_q(wr);
            zi_r    <= sat_q(wi);
            n_r     <= n_r + 1'b1;
            state_r <= S_RR;
          end
          ch_r <= '0;
        end
        S_COL: begin
          if (limit_r == '0) begin
            col_r[0] <= '0;
            col_r[1] <= '0;
            col_r[2] <= '0;
            state_r  <= S_DONE;
          end else begin
            rem_r   <= numer;
            dvs_r   <= {limit_r, 7'b0};
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_r >= 24'(dvs_r)) begin
            rem_r <= rem_r - 24'(dvs_r);
            q_r   <= {q_r[COLOR_W-2:0], 1'b1};
          end else begin
            q_r   <= {q_r[COLOR_W-2:0], 1'b0};
          end
          dvs_r <= dvs_r >> 1;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 3'd7) begin
            col_r[ch_r] <= {q_r[COLOR_W-2:0], (rem_r >= 24'(dvs_r))};
            if (ch_r == 2'd2) begin
              state_r <= S_DONE;
            end else begin
              ch_r    <= ch_r + 1'b1;
              state_r <= S_COL;
            end
          end
        end
        S_DONE: begin
          // hold until the output register is free for the transfer
          if (out_free) begin
            out_data_r  <= {n_r, col_r[2], col_r[1], col_r[0]};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== verif/mpc_checker.sv =====
// ----------------------------------------------------------------------------
// mpc_checker
// Watches the pixel, color and register channels of the escape-time
// coloring block, predicts the color of every accepted pixel from its own
// copy of the registers, and compares each color transfer with the oldest
// prediction.
// ----------------------------------------------------------------------------
module mpc_checker
  import mpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [23:0]       in_tdata,   // pixel_x[11:0], pixel_y[23:12]
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [39:0]       out_tdata,  // red, green, blue, escape_count
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [STEP_W-1:0] cfg_data,
  input  logic              end_check,
  output int                fail_count,
  output int                pending
);

  localparam int ACC_W = PROD_W + 8;
  localparam longint Q_HI = (64'sd1 <<< (Q_W - 1)) - 64'sd1;
  localparam longint Q_LO = -Q_HI - 64'sd1;
  // |z|^2 threshold of 4.0 at the scale of a full-width square
  localparam logic [ACC_W-1:0] ESCAPE_R2 = ACC_W'(1) << (2 * FRAC_BITS + 2);

  typedef struct packed {
    logic [ITER_W-1:0]  count;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } pixel_color_t;

  logic [SIZE_W-1:0] width_q;
  logic [SIZE_W-1:0] height_q;
  logic [ITER_W-1:0] limit_q;
  logic [STEP_W-1:0] step_q;

  pixel_color_t color_q[$];
  pixel_color_t want_c;
  pixel_color_t got_c;
  int           errs   = 0;
  int           pend_r = 0;

  assign fail_count = errs;
  assign pending    = pend_r;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
    if (v > Q_HI) return Q_W'(Q_HI);
    if (v < Q_LO) return Q_W'(Q_LO);
    return v[Q_W-1:0];
  endfunction

  // offset is taken in half pixels, so an odd size centers between pixels
  function automatic logic signed [Q_W-1:0] to_coord(input logic [POS_W-1:0]  pos,
                                                     input logic [SIZE_W-1:0] size);
    logic signed [ACC_W-1:0] off2;
    logic signed [ACC_W-1:0] prod;
    off2 = $signed(ACC_W'({pos, 1'b0})) - $signed(ACC_W'(size));
    prod = off2 * $signed(ACC_W'(step_q));
    return sat_q(prod >>> 1);
  endfunction

  function automatic pixel_color_t color_pixel(input logic [POS_W-1:0] px,
                                               input logic [POS_W-1:0] py);
    logic signed [Q_W-1:0]   cr;
    logic signed [Q_W-1:0]   ci;
    logic signed [Q_W-1:0]   zr;
    logic signed [Q_W-1:0]   zi;
    logic signed [ACC_W-1:0] cr_w;
    logic signed [ACC_W-1:0] ci_w;
    logic signed [ACC_W-1:0] re_t;
    logic signed [ACC_W-1:0] im_t;
    logic [Q_W-1:0]          ar;
    logic [Q_W-1:0]          ai;
    logic [ACC_W-1:0]        rr;
    logic [ACC_W-1:0]        ii;
    logic [ACC_W-1:0]        ri;
    int unsigned             lim;
    int unsigned             n;
    pixel_color_t            res;
    cr   = to_coord(px, width_q);
    ci   = to_coord(py, height_q);
    cr_w = ACC_W'(cr);
    ci_w = ACC_W'(ci);
    lim  = 32'(limit_q);
    n    = 0;
    zr   = '0;
    zi   = '0;
    while (n < lim) begin
      ar = zr[Q_W-1] ? -zr : zr;
      ai = zi[Q_W-1] ? -zi : zi;
      rr = ACC_W'(ar) * ACC_W'(ar);
      ii = ACC_W'(ai) * ACC_W'(ai);
      ri = ACC_W'(ar) * ACC_W'(ai);
      if (rr + ii > ESCAPE_R2) break;
      if (zr[Q_W-1] != zi[Q_W-1]) ri = -ri;
      re_t = $signed(rr - ii);
      im_t = $signed(ri);
      // 2*zr*zi comes from one fewer bit of shift
      zr = sat_q((re_t >>> FRAC_BITS) + cr_w);
      zi = sat_q((im_t >>> (FRAC_BITS - 1)) + ci_w);
      n++;
    end
    res = '0;
    if (lim != 0) begin
      res.red   = COLOR_W'((255 * n) / lim);
      res.green = COLOR_W'((255 * ((2 * n) % lim)) / lim);
      res.blue  = COLOR_W'((255 * ((3 * n) % lim)) / lim);
    end
    res.count = ITER_W'(n);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] have);
    if (have !== want) begin
      $error("%s: expected %0d, got %0d", name, want, have);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      limit_q  <= LIMIT_RST;
      step_q   <= STEP_RST;
      color_q.delete();
      pend_r   <= 0;
    end else begin
      // pop before push so a color never meets the pixel taken at the same edge
      if (out_tvalid && out_tready) begin
        if (color_q.size() == 0) begin
          $error("color transfer with no pixel pending: %h", out_tdata);
          errs++;
        end else begin
          want_c = color_q.pop_front();
          got_c  = out_tdata;
          check_field("red", 32'(want_c.red), 32'(got_c.red));
          check_field("green", 32'(want_c.green), 32'(got_c.green));
          check_field("blue", 32'(want_c.blue), 32'(got_c.blue));
          check_field("escape_count", 32'(want_c.count), 32'(got_c.count));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
          CFG_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
          CFG_LIMIT:  limit_q  <= cfg_data[ITER_W-1:0];
          CFG_STEP:   step_q   <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        color_q.push_back(color_pixel(in_tdata[POS_W-1:0], in_tdata[2*POS_W-1:POS_W]));
      if (end_check && color_q.size() != 0) begin
        $error("%0d pixels never got a color", color_q.size());
        errs += color_q.size();
        color_q.delete();
      end
      pend_r <= color_q.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the escape-time coloring block: a directed set of pixels and
// register settings at the extremes, then random image setups with pixels
// mostly inside the image, under changing pixel gaps and color back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import mpc_pkg::*;

  localparam int CYCLE_LIMIT  = 10_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES  = 3000;
  localparam int BLOCKS       = 12;
  localparam int BLOCK_ITEMS  = 50;
  // 4.0 in Q4.28, the span of the plane across the image
  localparam logic [STEP_W-1:0] STEP_FOUR = STEP_W'(1) << (FRAC_BITS + 2);

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic [23:0]         in_tdata   = '0;
  logic                out_tready = 1'b0;
  logic                cfg_valid  = 1'b0;
  logic [1:0]          cfg_index  = CFG_WIDTH;
  logic [STEP_W-1:0]   cfg_data   = '0;
  logic                end_check  = 1'b0;
  logic                in_tready;
  logic                out_tvalid;
  logic [39:0]         out_tdata;
  logic                cfg_ready;
  int                  fail_count;
  int                  pending;

  int snd_idle  = 33;
  int rcv_idle  = 88;
  int hold_left = 0;

  mandelbrot_pixel_color u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mpc_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .end_check  (end_check),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // color sink: random stalls, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  task automatic send_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
    while ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    do @(posedge clk); while (!in_tready);
  endtask

  // pending is a registered copy, so the item of the last transfer is counted in the cycle after it
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [STEP_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                             input logic [ITER_W-1:0] lim, input logic [STEP_W-1:0] step);
    wait_idle();
    put_reg(CFG_WIDTH, STEP_W'(w));
    put_reg(CFG_HEIGHT, STEP_W'(h));
    put_reg(CFG_LIMIT, STEP_W'(lim));
    put_reg(CFG_STEP, step);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_block(input bit hold);
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic [ITER_W-1:0] lim;
    logic [STEP_W-1:0] step;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    int unsigned       pick;
    w    = SIZE_W'($urandom_range(4096, 1));
    h    = SIZE_W'($urandom_range(4096, 1));
    pick = $urandom_range(9);
    if (pick < 7)
      step = STEP_FOUR / w;
    else if (pick < 9)
      step = STEP_W'($urandom_range(STEP_FOUR, 0));
    else
      step = STEP_W'($urandom_range(4000));
    // small limits keep the run short; a few setups go deeper
    if ($urandom_range(9) < 8)
      lim = ITER_W'($urandom_range(80, 1));
    else
      lim = ITER_W'($urandom_range(400, 81));
    load_config(w, h, lim, step);
    if (hold) hold_left = HOLD_CYCLES;
    repeat (BLOCK_ITEMS) begin
      if ($urandom_range(99) < 85) begin
        x = POS_W'($urandom_range(w - 1));
        y = POS_W'($urandom_range(h - 1));
      end else begin
        x = POS_W'($urandom());
        y = POS_W'($urandom());
      end
      send_pixel(x, y);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset setup: center and left point inside, corners escape after one iteration
    send_pixel(500, 500);
    send_pixel(0, 0);
    send_pixel(4095, 4095);
    send_pixel(0, 4095);
    send_pixel(4095, 0);
    send_pixel(250, 500);

    // odd width at a step of 4.0 and the largest limit; (0,1) lands on -2, which never escapes
    load_config(1, 2, 16'hFFFF, STEP_FOUR);
    send_pixel(0, 1);
    send_pixel(0, 0);
    send_pixel(4095, 4095);

    // zero size: far pixels saturate, zero limit gives black
    load_config(0, 0, 0, STEP_FOUR);
    send_pixel(0, 0);
    send_pixel(4095, 4095);

    load_config(0, 0, 1, STEP_FOUR);
    send_pixel(0, 0);
    send_pixel(4095, 0);

    // zero step puts every pixel at the origin
    load_config(4096, 4096, 7, '0);
    send_pixel(123, 4095);
    send_pixel(4095, 0);

    load_config(999, 777, 255, STEP_W'(STEP_FOUR / 999));
    send_pixel(499, 388);
    send_pixel(0, 776);
    send_pixel(998, 0);
    send_pixel(300, 400);

    for (int b = 0; b < BLOCKS; b++) begin
      if (b == BLOCKS / 3) begin
        snd_idle = 88;
        rcv_idle = 33;
      end else if (b == 2 * BLOCKS / 3) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      run_block(b == 2 * BLOCKS / 3 + 1);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    @(posedge clk);
    end_check <= 1'b0;
    @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
